// ----- design/hds_pkg.sv -----
// ----------------------------------------------------------------------------
// hds_pkg: shared constants and types for the HTML signature detector.
// Holds the pattern table, register codes and the matcher result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

    // Configuration register widths, resets and codes.
    localparam int        WINDOW_W            = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1024;
    localparam logic      CHECK_RESET         = 1'b1;
    localparam int        INDEX_WIDTH_DEFAULT = 16;
    localparam int        ADDR_W              = 3;
    localparam logic      REG_WINDOW          = 1'b0;
    localparam logic      REG_CHECK           = 1'b1;

    // Pattern set: seven tag names, then the doctype and the comment opener.
    localparam int        PAT_COUNT  = 9;
    localparam int        TAG_COUNT  = 7;
    localparam int        OFFSET_W   = 4;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 4'hF;
    localparam logic [7:0] LT_CHAR   = 8'h3C;

    // Character k of a pattern sits at bits [8*k +: 8], all in lower case.
    localparam logic [63:0] PAT_TEXT [PAT_COUNT] = '{
        {32'h0, "lmth"},
        {32'h0, "daeh"},
        {32'h0, "ydob"},
        {32'h0, "atem"},
        {40'h0, "vid"},
        {16'h0, "tpircs"},
        {24'h0, "elyts"},
        "epytcod!",
        {40'h0, "--!"}
    };

    localparam logic [OFFSET_W-1:0] PAT_LEN [PAT_COUNT] = '{
        4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd8, 4'd3
    };

    // Matcher result for one byte.
    typedef struct packed {
        logic [PAT_COUNT-1:0] alive;
        logic                 hit;
    } match_t;

endpackage

`default_nettype wire

// ----- design/hds_match.sv -----
// ----------------------------------------------------------------------------
// hds_match: compares one byte against every live pattern.
// Returns the surviving candidates and whether a signature completed.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_match
    import hds_pkg::*;
(
    input  wire logic [7:0]           data_byte,
    input  wire logic [PAT_COUNT-1:0] alive,
    input  wire logic [OFFSET_W-1:0]  offset,
    output match_t                    result
);

    logic [7:0] lower_byte;
    logic       boundary;

    // Fold upper-case letters to lower case.
    always_comb
    begin
        if (data_byte >= "A" && data_byte <= "Z")
        begin
            lower_byte = data_byte + 8'd32;
        end
        else
        begin
            lower_byte = data_byte;
        end
    end

    // Bytes that may close a tag name.
    assign boundary = (data_byte == ">")   || (data_byte == "/")   ||
                      (data_byte == " ")   || (data_byte == 8'h09) ||
                      (data_byte == 8'h0A) || (data_byte == 8'h0D) ||
                      (data_byte == 8'h0C);

    // Step every live candidate by one byte.
    always_comb
    begin
        result.alive = alive;
        result.hit   = 1'b0;
        for (int p = 0; p < PAT_COUNT; p++)
        begin
            if (alive[p])
            begin
                if (offset < PAT_LEN[p])
                begin
                    if (lower_byte == PAT_TEXT[p][{offset[2:0], 3'b000} +: 8])
                    begin
                        // Doctype and comment complete on their last character.
                        if (offset == PAT_LEN[p] - 4'd1 && p >= TAG_COUNT)
                        begin
                            result.hit      = 1'b1;
                            result.alive[p] = 1'b0;
                        end
                    end
                    else
                    begin
                        result.alive[p] = 1'b0;
                    end
                end
                else
                begin
                    // A tag name needs a boundary byte right after it.
                    if (offset == PAT_LEN[p] && p < TAG_COUNT && boundary)
                    begin
                        result.hit = 1'b1;
                    end
                    result.alive[p] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/html_signature_detector_top.sv -----
// ----------------------------------------------------------------------------
// html_signature_detector_top: flags buffers that carry an HTML signature.
// A word that ends a buffer gives its result via the input register and then the result register.
// Throughput: one byte word per cycle while in_stall is low; the match state updates once per byte.
// Reset: rst_n clears all scan state; window is 1024 and checking is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module html_signature_detector_top
    import hds_pkg::*;
#(
    parameter int IndexWidth = INDEX_WIDTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // Byte input channel.
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_buffer,
    // Result channel.
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   html_found
);

    localparam int CmpW = (IndexWidth > WINDOW_W) ? IndexWidth : WINDOW_W;

    logic [WINDOW_W-1:0]   window_reg;
    logic                  check_reg;
    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_end_reg;
    logic [IndexWidth-1:0] index_reg;
    logic [IndexWidth-1:0] index_next;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [OFFSET_W-1:0]   offset_next;
    logic [PAT_COUNT-1:0]  alive_reg;
    logic [PAT_COUNT-1:0]  alive_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic                  out_free;
    logic                  s1_fire;
    logic                  in_accept;
    logic                  cfg_write;
    logic                  index_full;
    logic                  in_window;
    logic                  tail_hit;
    match_t                match;

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            check_reg  <= CHECK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW: window_reg <= pwdata[WINDOW_W-1:0];
                REG_CHECK:  check_reg  <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW: prdata = {{(32-WINDOW_W){1'b0}}, window_reg};
            REG_CHECK:  prdata = {31'd0, check_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Handshake: the input register drains unless it holds a buffer end and a result word is blocked.
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!s1_end_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= end_of_buffer;
        end
    end

    // Pattern compare for the registered byte.
    hds_match u_match (
        .data_byte (s1_byte_reg),
        .alive     (alive_reg),
        .offset    (offset_reg),
        .result    (match)
    );

    // Window check, restart on an in-window '<', offset and index counting.
    assign index_full = (index_reg == {IndexWidth{1'b1}});
    assign in_window  = !index_full && (CmpW'(index_reg) < CmpW'(window_reg));

    always_comb
    begin
        if (s1_byte_reg == LT_CHAR && in_window)
        begin
            alive_next  = {PAT_COUNT{1'b1}};
            offset_next = '0;
        end
        else
        begin
            alive_next  = match.alive;
            offset_next = (offset_reg == OFFSET_MAX) ? offset_reg
                                                     : offset_reg + 4'd1;
        end
        index_next = index_full ? index_reg : index_reg + 1'b1;
    end

    // A tag name that runs into the buffer end counts as a hit.
    always_comb
    begin
        tail_hit = 1'b0;
        for (int p = 0; p < TAG_COUNT; p++)
        begin
            if (alive_next[p] && offset_next == PAT_LEN[p])
            begin
                tail_hit = 1'b1;
            end
        end
        found_next = found_reg || match.hit || (s1_end_reg && tail_hit);
    end

    // Scan state, cleared after each buffer end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            offset_reg <= '0;
            alive_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_end_reg)
            begin
                index_reg  <= '0;
                offset_reg <= '0;
                alive_reg  <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                index_reg  <= index_next;
                offset_reg <= offset_next;
                alive_reg  <= alive_next;
                found_reg  <= found_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_end_reg)
        begin
            out_found_reg <= found_next && check_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign html_found = out_found_reg;

endmodule

`default_nettype wire
